### rtl/vertex_rotate_isometric_project_core_assert.svh
// Assertion macros for the vertex rotate and isometric projection core.
`ifndef VERTEX_ROTATE_ISOMETRIC_PROJECT_CORE_ASSERT_SVH
`define VERTEX_ROTATE_ISOMETRIC_PROJECT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define VRIP_ASSERT_IMPL(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define VRIP_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/vrip_pkg.sv
// Package: widths, types, control structs and trig table builder for the vertex transform.
`default_nettype none

package vrip_pkg;

	// Field widths and fixed-point formats
	localparam int COORD_BITS     = 16;
	localparam int TRIG_FRAC_BITS = 14;
	localparam int ANGLE_STEPS    = 360;
	localparam int ANGLE_W        = 9;
	localparam int CFG_IDX_W      = 2;
	localparam int OUT_W          = 16;

	// Guard bits kept below the integer point of the coordinates
	localparam int KEEP_RAW  = 61 - COORD_BITS - TRIG_FRAC_BITS;
	localparam int KEEP_LIM  = (KEEP_RAW < 0) ? 0 : KEEP_RAW;
	localparam int KEEP_T    = (KEEP_LIM > TRIG_FRAC_BITS) ? TRIG_FRAC_BITS : KEEP_LIM;
	localparam int KEEP_BITS = (KEEP_T > 14) ? 14 : KEEP_T;

	localparam int TRIG_W = TRIG_FRAC_BITS + 2;
	localparam int VAL_W  = COORD_BITS + KEEP_BITS + 2;
	localparam int PROD_W = VAL_W + TRIG_W;
	localparam int SUM_W  = PROD_W + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [VAL_W-1:0]      val_t;
	typedef logic signed [TRIG_W-1:0]     trig_val_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [SUM_W-1:0]      sum_t;
	typedef logic signed [OUT_W-1:0]      out_t;
	typedef logic [ANGLE_W-1:0]           angle_t;
	typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;
	typedef logic [ANGLE_STEPS-1:0][TRIG_W-1:0] trig_tab_t;

	// Sine and cosine of the three angles, held by the config block
	typedef struct packed {
		trig_val_t cos_x;
		trig_val_t sin_x;
		trig_val_t cos_y;
		trig_val_t sin_y;
		trig_val_t cos_z;
		trig_val_t sin_z;
	} trig_cfg_t;

	// Stage load enables for one rotation unit
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
	} rot_ctl_t;

	// Stage load enables for the projection unit
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
	} proj_ctl_t;

	// Angle series constants, in units of 1e-9 rad
	localparam longint NANO         = 64'sd1000000000;
	localparam longint STEP_NANO    = 64'sd17450000;
	localparam longint PI_NANO      = 64'sd3141592654;
	localparam longint HALF_PI_NANO = 64'sd1570796327;
	localparam longint TWO_PI_NANO  = 64'sd6283185307;

	// Series divisors per term: (2k)(2k+1) for sine, (2k-1)(2k) for cosine
	localparam longint SIN_DIV [1:12] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110,
		64'sd156, 64'sd210, 64'sd272, 64'sd342, 64'sd420, 64'sd506, 64'sd600};
	localparam longint COS_DIV [1:12] = '{64'sd2, 64'sd12, 64'sd30, 64'sd56, 64'sd90,
		64'sd132, 64'sd182, 64'sd240, 64'sd306, 64'sd380, 64'sd462, 64'sd552};

	// Nano units to Q TRIG_FRAC_BITS, rounding half away from zero
	function automatic longint trig_to_q(input longint nano_val);
		longint m;
		longint r;
		m = (nano_val < 0) ? -nano_val : nano_val;
		r = ((m <<< TRIG_FRAC_BITS) + NANO / 2) / NANO;
		return (nano_val < 0) ? -r : r;
	endfunction

	// Builds the sine or cosine table by a truncated Taylor series, at elaboration
	function automatic trig_tab_t build_trig_tab(input logic want_sin);
		trig_tab_t tab;
		longint    t;
		longint    t2;
		longint    st;
		longint    ss;
		longint    ct;
		longint    cs;
		longint    q;
		logic      neg;
		int        i;
		int        k;
		tab = '0;
		for (i = 0; i < ANGLE_STEPS; i++) begin
			t   = longint'(i) * STEP_NANO;
			neg = 1'b0;
			if (t > PI_NANO) t = t - TWO_PI_NANO;
			if (t > HALF_PI_NANO) begin
				t   = PI_NANO - t;
				neg = 1'b1;
			end else if (t < -HALF_PI_NANO) begin
				t   = -PI_NANO - t;
				neg = 1'b1;
			end
			t2 = t * t / NANO;
			st = t;
			ss = t;
			ct = NANO;
			cs = NANO;
			for (k = 1; k <= 12; k++) begin
				st = st * t2 / NANO;
				st = -(st / SIN_DIV[k]);
				ss = ss + st;
				ct = ct * t2 / NANO;
				ct = -(ct / COS_DIV[k]);
				cs = cs + ct;
			end
			if (want_sin) q = trig_to_q(ss);
			else q = trig_to_q(neg ? -cs : cs);
			tab[i] = TRIG_W'(q);
		end
		return tab;
	endfunction

endpackage

`default_nettype wire

### rtl/vrip_trig.sv
// Angle registers: reduces each written angle and looks up its sine and cosine.
`default_nettype none

module vrip_trig import vrip_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire cfg_idx_t  cfg_addr,
	input  wire angle_t    cfg_wdata,
	output trig_cfg_t      trig
);

	localparam cfg_idx_t REG_ANGLE_X = 2'd0;
	localparam cfg_idx_t REG_ANGLE_Y = 2'd1;
	localparam cfg_idx_t REG_ANGLE_Z = 2'd2;

	localparam trig_tab_t COS_ROM = build_trig_tab(1'b0);
	localparam trig_tab_t SIN_ROM = build_trig_tab(1'b1);

	localparam angle_t    STEPS    = angle_t'(ANGLE_STEPS);
	localparam trig_val_t COS_ZERO = trig_val_t'(COS_ROM[0]);
	localparam trig_val_t SIN_ZERO = trig_val_t'(SIN_ROM[0]);

	angle_t    rom_addr;
	trig_val_t cos_x_q, sin_x_q, cos_y_q, sin_y_q, cos_z_q, sin_z_q;

	// Angle modulo the table length: one subtract covers the 9-bit range
	assign rom_addr = (cfg_wdata >= STEPS) ? (cfg_wdata - STEPS) : cfg_wdata;

	// Registered table read straight into the addressed angle's pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_x_q <= COS_ZERO;
			sin_x_q <= SIN_ZERO;
			cos_y_q <= COS_ZERO;
			sin_y_q <= SIN_ZERO;
			cos_z_q <= COS_ZERO;
			sin_z_q <= SIN_ZERO;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ANGLE_X: begin
					cos_x_q <= trig_val_t'(COS_ROM[rom_addr]);
					sin_x_q <= trig_val_t'(SIN_ROM[rom_addr]);
				end
				REG_ANGLE_Y: begin
					cos_y_q <= trig_val_t'(COS_ROM[rom_addr]);
					sin_y_q <= trig_val_t'(SIN_ROM[rom_addr]);
				end
				REG_ANGLE_Z: begin
					cos_z_q <= trig_val_t'(COS_ROM[rom_addr]);
					sin_z_q <= trig_val_t'(SIN_ROM[rom_addr]);
				end
				default: begin
					// no register at this index
				end
			endcase
		end
	end

	assign trig.cos_x = cos_x_q;
	assign trig.sin_x = sin_x_q;
	assign trig.cos_y = cos_y_q;
	assign trig.sin_y = sin_y_q;
	assign trig.cos_z = cos_z_q;
	assign trig.sin_z = sin_z_q;

endmodule

`default_nettype wire

### rtl/vrip_rotate.sv
// One plane rotation over two stages: products, then sum and rounding; third axis rides along.
`default_nettype none

module vrip_rotate import vrip_pkg::*; (
	input  wire logic      clk,
	input  wire rot_ctl_t  ctl,
	input  wire val_t      a,
	input  wire val_t      b,
	input  wire val_t      p,
	input  wire trig_val_t c,
	input  wire trig_val_t s,
	output val_t           a_out,
	output val_t           b_out,
	output val_t           p_out
);

	// Rounding offsets: half up for positive sums, mirrored for negative ones
	localparam sum_t RND_POS = sum_t'(1) <<< (TRIG_FRAC_BITS - 1);
	localparam sum_t RND_NEG = (sum_t'(1) <<< TRIG_FRAC_BITS) - sum_t'(1) - RND_POS;

	function automatic val_t round_trig(input sum_t v);
		sum_t biased;
		biased = v + (v[SUM_W-1] ? RND_NEG : RND_POS);
		return val_t'(biased >>> TRIG_FRAC_BITS);
	endfunction

	prod_t ac_s1, bs_s1, as_s1, bc_s1;
	val_t  p_s1;
	val_t  a_s2, b_s2, p_s2;

	// Stage 1: the four products
	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			ac_s1 <= prod_t'(a) * prod_t'(c);
			bs_s1 <= prod_t'(b) * prod_t'(s);
			as_s1 <= prod_t'(a) * prod_t'(s);
			bc_s1 <= prod_t'(b) * prod_t'(c);
			p_s1  <= p;
		end
	end

	// Stage 2: combine and round back to the coordinate format
	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			a_s2 <= round_trig(sum_t'(ac_s1) - sum_t'(bs_s1));
			b_s2 <= round_trig(sum_t'(as_s1) + sum_t'(bc_s1));
			p_s2 <= p_s1;
		end
	end

	assign a_out = a_s2;
	assign b_out = b_s2;
	assign p_out = p_s2;

endmodule

`default_nettype wire

### rtl/vrip_project.sv
// Isometric projection and painter depth over three stages, saturated to 16 bits.
`default_nettype none

module vrip_project import vrip_pkg::*; (
	input  wire logic      clk,
	input  wire proj_ctl_t ctl,
	input  wire val_t      x,
	input  wire val_t      y,
	input  wire val_t      z,
	output out_t           proj_u,
	output out_t           proj_v,
	output out_t           depth
);

	localparam int LIM_EXP = 18 + KEEP_BITS;
	localparam int NUM_W   = (VAL_W + 2 > LIM_EXP + 2) ? VAL_W + 2 : LIM_EXP + 2;
	localparam int K_W     = 31;
	localparam int PP_W    = NUM_W + K_W;
	localparam int PSHIFT  = 30 + KEEP_BITS;
	localparam int PSH_W   = PP_W - PSHIFT;
	localparam int DSUM_W  = VAL_W + 3;
	localparam int DSH_W   = DSUM_W - KEEP_BITS;
	localparam int SAT_W   = (PSH_W > DSH_W) ? PSH_W : DSH_W;

	typedef logic signed [NUM_W-1:0]  num_t;
	typedef logic signed [K_W-1:0]    k_t;
	typedef logic signed [PP_W-1:0]   pp_t;
	typedef logic signed [DSUM_W-1:0] dsum_t;
	typedef logic signed [SAT_W-1:0]  sat_t;

	// 1/sqrt2 and 1/sqrt6 in Q30
	localparam k_t INV_SQ2 = k_t'(759250125);
	localparam k_t INV_SQ6 = k_t'(438353264);

	localparam num_t  NUM_LIM  = num_t'(1) <<< LIM_EXP;
	localparam num_t  NUM_NLIM = -NUM_LIM;
	localparam pp_t   PBIAS    = (pp_t'(1) <<< PSHIFT) - pp_t'(1);
	localparam dsum_t DBIAS    = (dsum_t'(1) <<< KEEP_BITS) - dsum_t'(1);
	localparam sat_t  SAT_MAX  = sat_t'(32767);
	localparam sat_t  SAT_MIN  = sat_t'(-32768);

	function automatic num_t clamp_num(input num_t v);
		if (v > NUM_LIM) return NUM_LIM;
		if (v < NUM_NLIM) return NUM_NLIM;
		return v;
	endfunction

	function automatic out_t sat_out(input sat_t v);
		if (v > SAT_MAX) return out_t'(SAT_MAX);
		if (v < SAT_MIN) return out_t'(SAT_MIN);
		return out_t'(v);
	endfunction

	// Truncating shift of a scaled product, toward zero
	function automatic out_t scale_out(input pp_t v);
		pp_t biased;
		biased = v + (v[PP_W-1] ? PBIAS : pp_t'(0));
		return sat_out(sat_t'(biased >>> PSHIFT));
	endfunction

	num_t  u_num, v_num;
	dsum_t dsum, dbiased;

	num_t  u_num_s1, v_num_s1;
	out_t  depth_s1;
	pp_t   u_prod_s2, v_prod_s2;
	out_t  depth_s2;
	out_t  u_s3, v_s3, depth_s3;

	// Numerators and depth from the rotated vertex
	always_comb begin
		u_num   = num_t'(x) - num_t'(z);
		v_num   = num_t'(x) + (num_t'(y) <<< 1) + num_t'(z);
		dsum    = (dsum_t'(x) - dsum_t'(y) + dsum_t'(z)) <<< 1;
		dbiased = dsum + (dsum[DSUM_W-1] ? DBIAS : dsum_t'(0));
	end

	// Stage 1: clamped numerators, finished depth
	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			u_num_s1 <= clamp_num(u_num);
			v_num_s1 <= clamp_num(v_num);
			depth_s1 <= sat_out(sat_t'(dbiased >>> KEEP_BITS));
		end
	end

	// Stage 2: scale by the projection constants
	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			u_prod_s2 <= pp_t'(u_num_s1) * pp_t'(INV_SQ2);
			v_prod_s2 <= pp_t'(v_num_s1) * pp_t'(INV_SQ6);
			depth_s2  <= depth_s1;
		end
	end

	// Stage 3: truncate, saturate; this is the output register
	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			u_s3     <= scale_out(u_prod_s2);
			v_s3     <= scale_out(v_prod_s2);
			depth_s3 <= depth_s2;
		end
	end

	assign proj_u = u_s3;
	assign proj_v = v_s3;
	assign depth  = depth_s3;

endmodule

`default_nettype wire

### rtl/vertex_rotate_isometric_project_core.sv
// Throughput: one word per cycle while the output is not stalled.
// A stalled output freezes only the full stages that have no empty stage ahead of them.
// Stages: two per rotation (products, round) for X, Y, Z, then three for the projection.
// Reset (arst_n low, asynchronous): all stage valids clear and all three angles read as zero.
// An angle write applies to each word that reaches that rotation's product stage after it.
`default_nettype none
`include "vertex_rotate_isometric_project_core_assert.svh"

module vertex_rotate_isometric_project_core import vrip_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire cfg_idx_t cfg_addr,
	input  wire angle_t   cfg_wdata,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire coord_t   coord_x,
	input  wire coord_t   coord_y,
	input  wire coord_t   coord_z,
	output logic          out_valid,
	input  wire logic     out_stall,
	output out_t          proj_u,
	output out_t          proj_v,
	output out_t          depth
);

	localparam int NUM_STAGES = 9;

	trig_cfg_t             trig;
	logic [NUM_STAGES:1]   valid_q;
	logic [NUM_STAGES:1]   adv;
	rot_ctl_t              ctl_x, ctl_y, ctl_z;
	proj_ctl_t             ctl_p;
	val_t                  x0, y0, z0;
	val_t                  x1, y1, z1;
	val_t                  x2, y2, z2;
	val_t                  x3, y3, z3;
	logic                  in_acc, out_acc;

	// Angle registers and table lookup
	vrip_trig u_trig (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.trig      (trig)
	);

	// A stage advances when it is empty or the one after it advances
	always_comb begin
		adv[NUM_STAGES] = !valid_q[NUM_STAGES] || !out_stall;
		for (int i = NUM_STAGES - 1; i >= 1; i--) begin
			adv[i] = !valid_q[i] || adv[i+1];
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (adv[1]) valid_q[1] <= in_valid;
			for (int i = 2; i <= NUM_STAGES; i++) begin
				if (adv[i]) valid_q[i] <= valid_q[i-1];
			end
		end
	end

	assign in_stall  = !adv[1];
	assign out_valid = valid_q[NUM_STAGES];
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;

	assign ctl_x = '{ld_s1: adv[1], ld_s2: adv[2]};
	assign ctl_y = '{ld_s1: adv[3], ld_s2: adv[4]};
	assign ctl_z = '{ld_s1: adv[5], ld_s2: adv[6]};
	assign ctl_p = '{ld_s1: adv[7], ld_s2: adv[8], ld_s3: adv[9]};

	// Integer coordinates into the working fixed-point format
	assign x0 = val_t'(coord_x) <<< KEEP_BITS;
	assign y0 = val_t'(coord_y) <<< KEEP_BITS;
	assign z0 = val_t'(coord_z) <<< KEEP_BITS;

	// About X: pair (y, z)
	vrip_rotate u_rot_x (
		.clk   (clk),
		.ctl   (ctl_x),
		.a     (y0),
		.b     (z0),
		.p     (x0),
		.c     (trig.cos_x),
		.s     (trig.sin_x),
		.a_out (y1),
		.b_out (z1),
		.p_out (x1)
	);

	// About Y: pair (z, x)
	vrip_rotate u_rot_y (
		.clk   (clk),
		.ctl   (ctl_y),
		.a     (z1),
		.b     (x1),
		.p     (y1),
		.c     (trig.cos_y),
		.s     (trig.sin_y),
		.a_out (z2),
		.b_out (x2),
		.p_out (y2)
	);

	// About Z: pair (x, y)
	vrip_rotate u_rot_z (
		.clk   (clk),
		.ctl   (ctl_z),
		.a     (x2),
		.b     (y2),
		.p     (z2),
		.c     (trig.cos_z),
		.s     (trig.sin_z),
		.a_out (x3),
		.b_out (y3),
		.p_out (z3)
	);

	// Screen coordinates and depth
	vrip_project u_proj (
		.clk    (clk),
		.ctl    (ctl_p),
		.x      (x3),
		.y      (y3),
		.z      (z3),
		.proj_u (proj_u),
		.proj_v (proj_v),
		.depth  (depth)
	);

	// Input is held off only when every stage holds a word behind a stalled output
	`VRIP_ASSERT_IMPL(a_stall_only_full, clk, arst_n, !(&valid_q), !in_stall,
		"input stalled with room in pipe")
	// Words in flight change only by what enters and leaves
	`VRIP_ASSERT_NEXT(a_occupancy, clk, arst_n, 1'b1,
		$countones(valid_q) == $countones($past(valid_q)) + int'($past(in_acc))
		- int'($past(out_acc)), "word lost or duplicated in pipe")
	// A free-running output never backs up the input
	`VRIP_ASSERT_IMPL(a_flow_through, clk, arst_n, !out_stall, !in_stall,
		"input stalled while output drains")

endmodule

`default_nettype wire
